// File: rtl/occupancy_grid_disk_inflation_assert.svh
// Assertion macros for the occupancy grid inflation block.
// Included by the top level; depends on nothing else.
`ifndef OCCUPANCY_GRID_DISK_INFLATION_ASSERT_SVH
`define OCCUPANCY_GRID_DISK_INFLATION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OGDI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ogdi: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define OGDI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ogdi: next-cycle check failed");

`endif

// File: rtl/ogdi_pkg.sv
// Shared constants for the occupancy grid inflation block.
// No dependencies.
`timescale 1ns / 1ps

package ogdi_pkg;

   localparam int MaxRows   = 256;
   localparam int MaxCols   = 128;
   localparam int MaxRadius = 15;

   localparam int RowW  = 8;                 // row index width
   localparam int ColW  = 7;                 // column index width
   localparam int RadW  = 4;                 // radius register width
   localparam int NRowW = 9;                 // rows_in_use width
   localparam int NColW = 8;                 // cols_in_use width
   localparam int AddrW = RowW + ColW;       // column-major cell address
   localparam int Depth = MaxRows * MaxCols;

   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 9;

   // csr register indexes
   localparam logic [CsrIdxW-1:0] CsrGridRadius = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrRowsInUse  = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrColsInUse  = 2'd2;

   // request kinds (req_tuser)
   localparam logic CmdWrite = 1'b0;
   localparam logic CmdQuery = 1'b1;

   localparam logic [RadW-1:0]  RadiusReset = 4'd4;
   localparam logic [NRowW-1:0] RowsReset   = 9'd180;
   localparam logic [NColW-1:0] ColsReset   = 8'd120;

   typedef logic [AddrW-1:0] addr_type;

endpackage

// File: rtl/occupancy_grid_disk_inflation.sv
// Occupancy grid with disk-shaped obstacle inflation. A one-bit grid of
// 256 rows by 128 columns sits in a single-port-read, single-port-write
// memory, column-major (address = col * 256 + row). A write transfer
// (req_tuser = 0) stores one cell and gives no response; the block stays ready.
// A query transfer (req_tuser = 1) scans the box of cells around the queried
// cell, clamped to the used region, reading one cell per cycle from the memory,
// and returns 1 on rsp_tdata[0] when some occupied cell lies at squared
// distance <= radius squared. A query scans the box (at most 31 * 31 cells at
// radius 15), drains the last read and hands over the result, paced by the
// single memory read port. A query outside the used region skips the scan and
// answers 0. The response sits in an output register, so a waiting response
// does not hold off the next request; a second query only stalls at its end
// if the first response is still untaken. Registers on the csr port must be
// written only while the block is idle; the block does not enforce this.
// The grid has no reset: a cell must be written before a query covers it.
`timescale 1ns / 1ps
`include "occupancy_grid_disk_inflation_assert.svh"

module occupancy_grid_disk_inflation (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] row, [14:8] col, [15] occupied
   input  logic        req_tuser,   // [0] cmd: 0 write, 1 query
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] inflated, [7:1] zero
   // configuration writes
   input  logic        csr_we,
   input  logic [ogdi_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [ogdi_pkg::CsrDataW-1:0] csr_wdata
);

   // controller states
   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StScan  = 2'd1;   // one memory read per cycle
   localparam logic [1:0] StDrain = 2'd2;   // last read data returns
   localparam logic [1:0] StDone  = 2'd3;   // hand result to output register

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [ogdi_pkg::RadW-1:0]  radius_ff, radius_in;
   logic [ogdi_pkg::NRowW-1:0] rows_ff, rows_in;
   logic [ogdi_pkg::NColW-1:0] cols_ff, cols_in;

   always_comb begin
      radius_in = radius_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            ogdi_pkg::CsrGridRadius: radius_in = csr_wdata[ogdi_pkg::RadW-1:0];
            ogdi_pkg::CsrRowsInUse:  rows_in   = csr_wdata[ogdi_pkg::NRowW-1:0];
            ogdi_pkg::CsrColsInUse:  cols_in   = csr_wdata[ogdi_pkg::NColW-1:0];
            default: ;              // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // request fields
   // ---------------------------------------------------------------------
   logic [ogdi_pkg::RowW-1:0] req_row;
   logic [ogdi_pkg::ColW-1:0] req_col;
   logic                      req_occ;
   logic                      req_fire;

   assign req_row  = req_tdata[7:0];
   assign req_col  = req_tdata[14:8];
   assign req_occ  = req_tdata[15];
   assign req_fire = req_tvalid && req_tready;

   // saturated used size and radius
   logic [ogdi_pkg::NRowW-1:0] nrows_eff, nrows_m1;
   logic [ogdi_pkg::NColW-1:0] ncols_eff, ncols_m1;
   logic [ogdi_pkg::RadW-1:0]  rad_eff;

   assign nrows_eff = (rows_ff > ogdi_pkg::NRowW'(ogdi_pkg::MaxRows))
                      ? ogdi_pkg::NRowW'(ogdi_pkg::MaxRows) : rows_ff;
   assign ncols_eff = (cols_ff > ogdi_pkg::NColW'(ogdi_pkg::MaxCols))
                      ? ogdi_pkg::NColW'(ogdi_pkg::MaxCols) : cols_ff;
   assign rad_eff   = (radius_ff > ogdi_pkg::RadW'(ogdi_pkg::MaxRadius))
                      ? ogdi_pkg::RadW'(ogdi_pkg::MaxRadius) : radius_ff;
   assign nrows_m1  = nrows_eff - 1'b1;
   assign ncols_m1  = ncols_eff - 1'b1;

   // search box of the incoming query, clamped to the used region
   logic                       q_outside;
   logic [ogdi_pkg::NRowW-1:0] row_plus;
   logic [ogdi_pkg::NColW-1:0] col_plus;
   logic [ogdi_pkg::RowW-1:0]  box_rlo, box_rhi;
   logic [ogdi_pkg::ColW-1:0]  box_clo, box_chi;

   assign q_outside = ({1'b0, req_row} >= nrows_eff) || ({1'b0, req_col} >= ncols_eff);
   assign row_plus  = {1'b0, req_row} + ogdi_pkg::NRowW'(rad_eff);
   assign col_plus  = {1'b0, req_col} + ogdi_pkg::NColW'(rad_eff);
   assign box_rlo   = (req_row > ogdi_pkg::RowW'(rad_eff))
                      ? req_row - ogdi_pkg::RowW'(rad_eff) : '0;
   assign box_clo   = (req_col > ogdi_pkg::ColW'(rad_eff))
                      ? req_col - ogdi_pkg::ColW'(rad_eff) : '0;
   assign box_rhi   = (row_plus > nrows_m1) ? nrows_m1[ogdi_pkg::RowW-1:0]
                                            : row_plus[ogdi_pkg::RowW-1:0];
   assign box_chi   = (col_plus > ncols_m1) ? ncols_m1[ogdi_pkg::ColW-1:0]
                                            : col_plus[ogdi_pkg::ColW-1:0];

   // ---------------------------------------------------------------------
   // query scan state
   // ---------------------------------------------------------------------
   logic [1:0]                state_ff, state_in;
   logic [ogdi_pkg::RowW-1:0] row0_ff, row0_in, rlo_ff, rlo_in, rhi_ff, rhi_in;
   logic [ogdi_pkg::RowW-1:0] r_ff, r_in;
   logic [ogdi_pkg::ColW-1:0] col0_ff, col0_in, chi_ff, chi_in, c_ff, c_in;
   logic [ogdi_pkg::RadW-1:0] rad_ff, rad_in;
   logic                      pend_ff, pend_in;  // read in flight is inside the disk
   logic                      hit_ff, hit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_bit_ff, rsp_bit_in;

   // distance test of the cell being issued
   logic [ogdi_pkg::RowW-1:0] dr_abs;
   logic [ogdi_pkg::ColW-1:0] dc_abs;
   logic [7:0]                dr2, dc2, rad2;
   logic [8:0]                dist2;
   logic                      in_disk;

   assign dr_abs  = (r_ff >= row0_ff) ? r_ff - row0_ff : row0_ff - r_ff;
   assign dc_abs  = (c_ff >= col0_ff) ? c_ff - col0_ff : col0_ff - c_ff;
   // box limits keep both offsets within the radius
   assign dr2     = dr_abs[ogdi_pkg::RadW-1:0] * dr_abs[ogdi_pkg::RadW-1:0];
   assign dc2     = dc_abs[ogdi_pkg::RadW-1:0] * dc_abs[ogdi_pkg::RadW-1:0];
   assign rad2    = rad_ff * rad_ff;
   assign dist2   = {1'b0, dr2} + {1'b0, dc2};
   assign in_disk = dist2 <= {1'b0, rad2};

   // memory control
   logic                mem_we;
   ogdi_pkg::addr_type  mem_waddr;
   ogdi_pkg::addr_type  mem_raddr;
   logic                rd_q;

   assign mem_we    = req_fire && (req_tuser == ogdi_pkg::CmdWrite);
   assign mem_waddr = {req_col, req_row};
   assign mem_raddr = {c_ff, r_ff};

   logic rsp_free;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == StIdle);

   always_comb begin
      state_in     = state_ff;
      row0_in      = row0_ff;
      col0_in      = col0_ff;
      rlo_in       = rlo_ff;
      rhi_in       = rhi_ff;
      chi_in       = chi_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      rad_in       = rad_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff | (pend_ff & rd_q);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bit_in   = rsp_bit_ff;

      unique case (state_ff)
         StIdle: begin
            if (req_fire && (req_tuser == ogdi_pkg::CmdQuery)) begin
               row0_in = req_row;
               col0_in = req_col;
               rlo_in  = box_rlo;
               rhi_in  = box_rhi;
               chi_in  = box_chi;
               r_in    = box_rlo;
               c_in    = box_clo;
               rad_in  = rad_eff;
               hit_in  = 1'b0;
               state_in = q_outside ? StDone : StScan;
            end
         end
         StScan: begin
            pend_in = in_disk;
            if (r_ff == rhi_ff) begin
               r_in = rlo_ff;
               if (c_ff == chi_ff) begin
                  state_in = StDrain;
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end else begin
               r_in = r_ff + 1'b1;
            end
         end
         StDrain: begin
            state_in = StDone;
         end
         StDone: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = hit_ff;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= ogdi_pkg::RadiusReset;
         rows_ff      <= ogdi_pkg::RowsReset;
         cols_ff      <= ogdi_pkg::ColsReset;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         radius_ff    <= radius_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
      end
   end

   always_ff @(posedge clock) begin
      row0_ff    <= row0_in;
      col0_ff    <= col0_in;
      rlo_ff     <= rlo_in;
      rhi_ff     <= rhi_in;
      chi_ff     <= chi_in;
      r_ff       <= r_in;
      c_ff       <= c_in;
      rad_ff     <= rad_in;
      hit_ff     <= hit_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   // ---------------------------------------------------------------------
   // grid memory: one write port, one registered read port
   // ---------------------------------------------------------------------
   logic grid_mem [0:ogdi_pkg::Depth-1];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= req_occ;
      end
   end

   always_ff @(posedge clock) begin
      rd_q <= grid_mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_bit_ff};

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `OGDI_ASSERT_NEXT(a_query_leaves_idle, clock, reset,
      req_fire && (req_tuser == ogdi_pkg::CmdQuery), state_ff != StIdle)
   `OGDI_ASSERT_SAME(a_pend_in_scan, clock, reset,
      pend_ff, (state_ff == StScan) || (state_ff == StDrain))
   `OGDI_ASSERT_SAME(a_scan_in_box, clock, reset,
      state_ff == StScan, (r_ff >= rlo_ff) && (r_ff <= rhi_ff) && (c_ff <= chi_ff))
   `OGDI_ASSERT_NEXT(a_write_no_rsp, clock, reset,
      mem_we && !rsp_valid_ff, !rsp_valid_ff)

endmodule
